FILE: hw/rtl/sclh_pkg.sv
// ----------------------------------------------------------------------------
// sclh_pkg
// Shared sizes for the simple cycle length histogram block.
// ----------------------------------------------------------------------------
package sclh_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int MAX_DEGREE   = 16;

   localparam int VTX_W   = 6;
   localparam int IDX_W   = 5;
   localparam int SLOT_W  = 5;
   localparam int SLOT_AW = 4;
   localparam int ADJ_AW  = IDX_W + SLOT_AW;
   localparam int ADJ_D   = MAX_VERTICES * MAX_DEGREE;
   localparam int CNT_W   = 32;
   localparam int STK_W   = VTX_W + SLOT_W;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [VTX_W-1:0] VTX_MAX = 6'd32;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_END = 1'b1;

   typedef logic [VTX_W-1:0] vtx_type;
   typedef logic [CNT_W-1:0] cnt_type;

endpackage

FILE: hw/rtl/simple_cycle_length_histogram.sv
// ----------------------------------------------------------------------------
// simple_cycle_length_histogram
// Loads adjacency lists, counts canonical simple cycles by length with a
// depth-first walk over on-chip memories, and streams out the histogram.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser / tlast
//  req_    | in  | vertex, neighbour_vertex, vertex_count, pad | tuser = func
//  rsp_    | out | cycle_length, cycle_count, pad              | tlast = last
//
//  An add item appends a neighbour to an adjacency list. An end item runs
//  the walk: each adjacency slot visited is read and then evaluated, a
//  backtrack pops the stack, then each length is scanned. The adjacency
//  and stack memory reads set the pace. Reset is synchronous and clears
//  degrees, marks and histogram. A stalled rsp_ output holds the scan;
//  req_ is taken only when idle.
module simple_cycle_length_histogram (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sclh_pkg::REQ_DATA_W-1:0]  req_tdata,  // vertex, neighbour_vertex, vertex_count
   input  logic                             req_tuser,  // func
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sclh_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // cycle_length, cycle_count
   output logic                             rsp_tlast   // last
);
   import sclh_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_OCHK  = 3'd1;
   localparam logic [2:0] S_OEVAL = 3'd2;
   localparam logic [2:0] S_WRD   = 3'd3;
   localparam logic [2:0] S_WEVAL = 3'd4;
   localparam logic [2:0] S_WPOP  = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]        state_ff, state_in;
   vtx_type           order_ff, order_in;
   vtx_type           ov_ff, ov_in;
   logic [SLOT_W-1:0] oi_ff, oi_in;
   vtx_type           second_ff, second_in;
   vtx_type           top_v_ff, top_v_in;
   logic [SLOT_W-1:0] top_s_ff, top_s_in;
   vtx_type           depth_ff, depth_in;
   vtx_type           e_ff, e_in;
   logic              pend_valid_ff, pend_valid_in;
   vtx_type           pend_len_ff, pend_len_in;
   cnt_type           pend_cnt_ff, pend_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   vtx_type           rsp_len_ff, rsp_len_in;
   cnt_type           rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [VTX_W-1:0]  adj_mem [ADJ_D];
   logic              adj_we;
   logic [ADJ_AW-1:0] adj_waddr, adj_raddr;
   vtx_type           adj_q;

   logic [STK_W-1:0]  stk_mem [MAX_VERTICES];
   logic              stk_we;
   logic [IDX_W-1:0]  stk_waddr, stk_raddr;
   logic [STK_W-1:0]  stk_wdata, stk_q;

   logic [SLOT_W-1:0] deg_ff [MAX_VERTICES];
   logic              mark_ff [MAX_VERTICES];
   cnt_type           hist_ff [MAX_VERTICES];

   logic              deg_inc;
   logic [IDX_W-1:0]  deg_idx;
   logic [SLOT_W-1:0] deg_rd;
   logic              mark_we, mark_val;
   logic [IDX_W-1:0]  mark_idx;
   logic              bump_en;
   logic [IDX_W-1:0]  hist_idx;
   cnt_type           hist_rd;
   logic              clear_all;

   vtx_type           in_vtx, in_nbr, in_cnt, nb;
   logic              req_fire, out_free, rsp_load;

   assign in_vtx   = req_tdata[5:0];
   assign in_nbr   = req_tdata[11:6];
   assign in_cnt   = req_tdata[17:12];
   assign nb       = adj_q;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  deg_idx = IDX_W'(in_vtx - 6'd1);
         S_OCHK:  deg_idx = IDX_W'(ov_ff - 6'd1);
         default: deg_idx = IDX_W'(top_v_ff - 6'd1);
      endcase
   end
   assign deg_rd  = deg_ff[deg_idx];
   assign hist_rd = hist_ff[hist_idx];

   always_comb begin
      state_in      = state_ff;
      order_in      = order_ff;
      ov_in         = ov_ff;
      oi_in         = oi_ff;
      second_in     = second_ff;
      top_v_in      = top_v_ff;
      top_s_in      = top_s_ff;
      depth_in      = depth_ff;
      e_in          = e_ff;
      pend_valid_in = pend_valid_ff;
      pend_len_in   = pend_len_ff;
      pend_cnt_in   = pend_cnt_ff;
      rsp_load      = 1'b0;
      rsp_len_in    = rsp_len_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      adj_we        = 1'b0;
      adj_waddr     = {IDX_W'(in_vtx - 6'd1), deg_rd[SLOT_AW-1:0]};
      adj_raddr     = {IDX_W'(top_v_ff - 6'd1), top_s_ff[SLOT_AW-1:0]};
      stk_we        = 1'b0;
      stk_waddr     = IDX_W'(depth_ff - 6'd1);
      stk_wdata     = {top_s_ff, top_v_ff};
      stk_raddr     = IDX_W'(depth_ff - 6'd2);
      deg_inc       = 1'b0;
      mark_we       = 1'b0;
      mark_val      = 1'b0;
      mark_idx      = IDX_W'(nb - 6'd1);
      bump_en       = 1'b0;
      hist_idx      = IDX_W'(e_ff - 6'd1);
      clear_all     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == FUNC_ADD) begin
                  if (in_vtx != 6'd0 && in_vtx <= VTX_MAX && in_nbr != 6'd0 &&
                      in_nbr <= VTX_MAX && deg_rd < SLOT_W'(MAX_DEGREE)) begin
                     adj_we  = 1'b1;
                     deg_inc = 1'b1;
                  end
               end else begin
                  order_in = (in_cnt > VTX_MAX) ? VTX_MAX : in_cnt;
                  ov_in    = 6'd1;
                  oi_in    = '0;
                  state_in = S_OCHK;
               end
            end
         end
         S_OCHK: begin
            mark_idx = IDX_W'(ov_ff - 6'd1);
            if (ov_ff >= order_ff) begin
               e_in          = 6'd1;
               pend_valid_in = 1'b0;
               state_in      = S_EMIT;
            end else if (oi_ff >= deg_rd) begin
               mark_we = 1'b1;
               ov_in   = ov_ff + 6'd1;
               oi_in   = '0;
            end else begin
               mark_we   = 1'b1;
               mark_val  = 1'b1;
               adj_raddr = {IDX_W'(ov_ff - 6'd1), oi_ff[SLOT_AW-1:0]};
               oi_in     = oi_ff + 5'd1;
               state_in  = S_OEVAL;
            end
         end
         S_OEVAL: begin
            if (nb <= ov_ff || nb > order_ff) begin
               state_in = S_OCHK;
            end else begin
               mark_we   = 1'b1;
               mark_val  = 1'b1;
               second_in = nb;
               top_v_in  = nb;
               top_s_in  = '0;
               depth_in  = 6'd1;
               state_in  = S_WRD;
            end
         end
         S_WRD: begin
            if (top_s_ff >= deg_rd) begin
               mark_we  = 1'b1;
               mark_idx = IDX_W'(top_v_ff - 6'd1);
               depth_in = depth_ff - 6'd1;
               state_in = (depth_ff == 6'd1) ? S_OCHK : S_WPOP;
            end else begin
               top_s_in = top_s_ff + 5'd1;
               state_in = S_WEVAL;
            end
         end
         S_WEVAL: begin
            state_in = S_WRD;
            hist_idx = depth_ff[IDX_W-1:0];
            if (nb > order_ff) begin
               state_in = S_WRD;
            end else if (nb != ov_ff && mark_ff[IDX_W'(nb - 6'd1)]) begin
               state_in = S_WRD;
            end else if (nb < ov_ff) begin
               state_in = S_WRD;
            end else if (nb == ov_ff) begin
               if (top_v_ff > second_ff && depth_ff <= 6'd31) begin
                  bump_en = 1'b1;
               end
            end else if (depth_ff < VTX_MAX) begin
               stk_we   = 1'b1;
               mark_we  = 1'b1;
               mark_val = 1'b1;
               top_v_in = nb;
               top_s_in = '0;
               depth_in = depth_ff + 6'd1;
            end
         end
         S_WPOP: begin
            top_v_in = stk_q[VTX_W-1:0];
            top_s_in = stk_q[STK_W-1:VTX_W];
            state_in = S_WRD;
         end
         S_EMIT: begin
            if (e_ff <= VTX_MAX) begin
               if (hist_rd == '0) begin
                  e_in = e_ff + 6'd1;
               end else if (!pend_valid_ff) begin
                  pend_valid_in = 1'b1;
                  pend_len_in   = e_ff;
                  pend_cnt_in   = hist_rd;
                  e_in          = e_ff + 6'd1;
               end else if (out_free) begin
                  rsp_load    = 1'b1;
                  rsp_len_in  = pend_len_ff;
                  rsp_cnt_in  = pend_cnt_ff;
                  rsp_last_in = 1'b0;
                  pend_len_in = e_ff;
                  pend_cnt_in = hist_rd;
                  e_in        = e_ff + 6'd1;
               end
            end else if (out_free) begin
               rsp_load    = 1'b1;
               rsp_len_in  = pend_valid_ff ? pend_len_ff : '0;
               rsp_cnt_in  = pend_valid_ff ? pend_cnt_ff : '0;
               rsp_last_in = 1'b1;
               clear_all   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= in_nbr;
      end
      adj_q <= adj_mem[adj_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_q <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            deg_ff[i]  <= '0;
            mark_ff[i] <= 1'b0;
            hist_ff[i] <= '0;
         end
      end else begin
         if (deg_inc) begin
            deg_ff[deg_idx] <= deg_rd + 5'd1;
         end
         if (mark_we) begin
            mark_ff[mark_idx] <= mark_val;
         end
         if (bump_en && hist_rd != '1) begin
            hist_ff[hist_idx] <= hist_rd + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff    <= order_in;
      ov_ff       <= ov_in;
      oi_ff       <= oi_in;
      second_ff   <= second_in;
      top_v_ff    <= top_v_in;
      top_s_ff    <= top_s_in;
      depth_ff    <= depth_in;
      e_ff        <= e_in;
      pend_len_ff <= pend_len_in;
      pend_cnt_ff <= pend_cnt_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_cnt_ff, rsp_len_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/sclh_checker.sv
// ----------------------------------------------------------------------------
// sclh_checker
// Port-level checks for the simple cycle length histogram block.
// ----------------------------------------------------------------------------
module sclh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sclh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import sclh_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5:0] == 6'd0 |-> rsp_tlast && rsp_tdata[37:6] == '0)
      else $error("empty result not final");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] <= VTX_MAX)
      else $error("cycle length out of range");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5:0] != 6'd0 |-> rsp_tdata[37:6] != '0)
      else $error("zero count for listed length");

endmodule

bind simple_cycle_length_histogram sclh_checker u_sclh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
